// ===== rtl/core/dsc_pkg.sv =====
// Shared definitions for the distinct subsequence counter.
// Request codes, status codes and stream field widths; no dependencies.
package dsc_pkg;

  localparam int SYM_W    = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int MATCH_W  = 32;

  // Request codes carried on in_tuser.
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;

  // Status codes carried on out_tuser.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

endpackage

// ===== rtl/core/distinct_subsequence_counter.sv =====
// Distinct subsequence counter: pattern store, count row memory and the
// sequencer that walks the count row with one shared saturating adder.
// Depends on dsc_pkg.
//
// Counts how often the loaded pattern occurs as a subsequence of the text
// streamed so far. Each request gives exactly one result. A clear, an append
// or an unused code is answered straight from the idle state. A text symbol
// with a non-empty pattern is accepted while the top count entry is fetched,
// then the read pipeline is primed and the positions are walked, since
// the count row lives in a single-port-read memory and one adder updates one
// entry per cycle from the top down. in_tready is low while a text symbol is
// being worked on. Counts saturate at 2**COUNT_BITS - 1; the result carries
// the low 32 bits of the count.
module distinct_subsequence_counter #(
  parameter int MAX_PATTERN = 32,
  parameter int COUNT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] match_count
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);
  localparam logic [LEN_W-1:0] ONE_L   = LEN_W'(1);
  localparam logic [LEN_W-1:0] TWO_L   = LEN_W'(2);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {S_IDLE, S_PRIME, S_STEP} state_t;

  state_t                          state_r;
  logic [LEN_W-1:0]                len_r;
  logic [LEN_W-1:0]                j_r;
  logic [COUNT_BITS-1:0]           a_r;
  logic [COUNT_BITS-1:0]           cur_r;
  logic [dsc_pkg::SYM_W-1:0]       sym_r;
  logic                            text_seen_r;
  logic                            sat_r;
  logic [MAX_PATTERN-1:0]          vld_r;
  logic                            out_valid_r;
  logic [dsc_pkg::MATCH_W-1:0]     out_count_r;
  logic [dsc_pkg::STATUS_W-1:0]    out_status_r;

  // Memories and their registered read data.
  logic [dsc_pkg::SYM_W-1:0]       pat_mem [MAX_PATTERN];
  logic [COUNT_BITS-1:0]           cnt_mem [MAX_PATTERN];
  logic [dsc_pkg::SYM_W-1:0]       pat_rd_r;
  logic [COUNT_BITS-1:0]           cnt_rd_r;
  logic                            rd_zero_r;
  logic                            rd_vld_r;

  logic                            in_fire;
  logic                            cnt_re;
  logic                            pat_re;
  logic [LEN_W-1:0]                rd_row;
  logic [LEN_W-1:0]                rd_row_m1;
  logic [LEN_W-1:0]                j_m1;
  logic [COUNT_BITS-1:0]           eff;
  logic                            sym_match;
  logic [COUNT_BITS:0]             sum;
  logic [COUNT_BITS-1:0]           new_a;
  logic                            sat_step;
  logic                            wr_en;
  logic                            app_wr;
  logic [COUNT_BITS-1:0]           count_now;
  logic [COUNT_BITS+31:0]          count_now_ext;
  logic [COUNT_BITS+31:0]          new_a_ext;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = out_status_r;

  // Read address is a count row index; the pattern position read with it
  // has the same index, so pattern and row for one step arrive together.
  always_comb begin
    cnt_re = 1'b0;
    pat_re = 1'b0;
    rd_row = len_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_re = in_fire && (in_tuser == dsc_pkg::OP_TEXT) && (len_r != '0);
        rd_row = len_r;
      end
      S_PRIME: begin
        cnt_re = 1'b1;
        pat_re = 1'b1;
        rd_row = j_r - ONE_L;
      end
      S_STEP: begin
        cnt_re = (j_r > ONE_L);
        pat_re = (j_r > ONE_L);
        rd_row = j_r - TWO_L;
      end
      default: begin
        cnt_re = 1'b0;
      end
    endcase
  end

  assign rd_row_m1 = rd_row - ONE_L;
  assign j_m1      = j_r - ONE_L;

  // Row zero is never stored and always reads as one; an entry not written
  // since the last restart reads as zero.
  assign eff = rd_zero_r ? COUNT_BITS'(1) : (rd_vld_r ? cnt_rd_r : '0);

  assign sym_match = (pat_rd_r == sym_r);
  assign sum       = {1'b0, a_r} + {1'b0, eff};
  assign sat_step  = sym_match && sum[COUNT_BITS];
  assign new_a     = sym_match ? (sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0]) : a_r;
  assign wr_en     = (state_r == S_STEP) && sym_match;
  assign app_wr    = in_fire && (in_tuser == dsc_pkg::OP_APPEND) && (len_r != LEN_MAX);

  assign count_now     = (text_seen_r && (len_r != '0)) ? cur_r : '0;
  assign count_now_ext = {32'b0, count_now};
  assign new_a_ext     = {32'b0, ((j_r == len_r) ? new_a : cur_r)};

  always_ff @(posedge clk) begin
    if (app_wr) begin
      pat_mem[len_r[IDX_W-1:0]] <= in_tdata;
    end
    if (wr_en) begin
      cnt_mem[j_m1[IDX_W-1:0]] <= new_a;
    end
    if (pat_re) begin
      pat_rd_r <= pat_mem[rd_row[IDX_W-1:0]];
    end
    if (cnt_re) begin
      cnt_rd_r  <= cnt_mem[rd_row_m1[IDX_W-1:0]];
      rd_zero_r <= (rd_row == '0);
      rd_vld_r  <= vld_r[rd_row_m1[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      len_r        <= '0;
      j_r          <= '0;
      cur_r        <= '0;
      text_seen_r  <= 1'b0;
      sat_r        <= 1'b0;
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
      out_count_r  <= '0;
      out_status_r <= dsc_pkg::ST_OK;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            out_valid_r <= 1'b1;
            case (in_tuser)
              dsc_pkg::OP_CLEAR: begin
                len_r        <= '0;
                vld_r        <= '0;
                text_seen_r  <= 1'b0;
                sat_r        <= 1'b0;
                cur_r        <= '0;
                out_count_r  <= '0;
                out_status_r <= dsc_pkg::ST_OK;
              end
              dsc_pkg::OP_APPEND: begin
                if (len_r != LEN_MAX) begin
                  len_r        <= len_r + ONE_L;
                  vld_r        <= '0;
                  text_seen_r  <= 1'b0;
                  sat_r        <= 1'b0;
                  cur_r        <= '0;
                  out_count_r  <= '0;
                  out_status_r <= dsc_pkg::ST_OK;
                end else begin
                  out_count_r  <= count_now_ext[31:0];
                  out_status_r <= dsc_pkg::ST_FULL;
                end
              end
              dsc_pkg::OP_TEXT: begin
                text_seen_r <= 1'b1;
                sym_r       <= in_tdata;
                if (len_r == '0) begin
                  out_count_r  <= '0;
                  out_status_r <= sat_r ? dsc_pkg::ST_SAT : dsc_pkg::ST_OK;
                end else begin
                  // Result is held back until the row walk is done.
                  out_valid_r <= 1'b0;
                  j_r         <= len_r;
                  state_r     <= S_PRIME;
                end
              end
              default: begin
                out_count_r  <= count_now_ext[31:0];
                out_status_r <= sat_r ? dsc_pkg::ST_SAT : dsc_pkg::ST_OK;
              end
            endcase
          end
        end
        S_PRIME: begin
          a_r     <= eff;
          state_r <= S_STEP;
        end
        S_STEP: begin
          if (sym_match) begin
            vld_r[j_m1[IDX_W-1:0]] <= 1'b1;
          end
          if (j_r == len_r) begin
            cur_r <= new_a;
          end
          sat_r <= sat_r || sat_step;
          // The old entry below becomes the upper operand of the next step.
          a_r   <= eff;
          j_r   <= j_m1;
          if (j_r == ONE_L) begin
            out_valid_r  <= 1'b1;
            out_count_r  <= new_a_ext[31:0];
            out_status_r <= (sat_r || sat_step) ? dsc_pkg::ST_SAT : dsc_pkg::ST_OK;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Stream testbench for the distinct subsequence counter: stimulus queue, driver,
// monitor and an in-bench count predictor. Depends on dsc_pkg and the counter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAT_DEPTH = 32;
  localparam int CNT_W     = 32;
  localparam logic [dsc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 850;

  typedef struct {
    logic [dsc_pkg::OP_W-1:0]  opcode;
    logic [dsc_pkg::SYM_W-1:0] symbol;
    bit                        wait_idle;
  } req_t;

  typedef struct {
    logic [dsc_pkg::MATCH_W-1:0]  count;
    logic [dsc_pkg::STATUS_W-1:0] status;
  } match_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [dsc_pkg::SYM_W-1:0] in_tdata = '0;
  logic [dsc_pkg::OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [dsc_pkg::MATCH_W-1:0] out_tdata;
  logic [dsc_pkg::STATUS_W-1:0] out_tuser;

  req_t   req_q[$];
  match_t match_q[$];

  // Predictor state: pattern, one row of partial counts and the two flags.
  logic [dsc_pkg::SYM_W-1:0] pat_mem [PAT_DEPTH];
  int unsigned               pat_len;
  logic [CNT_W-1:0]          row [PAT_DEPTH+1];
  bit                        text_on;
  bit                        sat_on;

  int n_errors = 0;
  int n_accepted = 0;
  int n_results = 0;
  int gap_left = 0;
  int rstall = 0;
  int cycle_no = 0;
  int long_hold = 0;

  logic [dsc_pkg::SYM_W-1:0] alph [4];
  int alph_n;

  distinct_subsequence_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] symbol
    .in_tuser   (in_tuser),   // [1:0] opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] match_count
    .out_tuser  (out_tuser)   // [1:0] status
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic void restart_text();
    for (int j = 0; j <= PAT_DEPTH; j++) row[j] = '0;
    row[0] = 1;
    text_on = 1'b0;
    sat_on = 1'b0;
  endfunction

  function automatic void step_counter(logic [dsc_pkg::OP_W-1:0] op,
                                       logic [dsc_pkg::SYM_W-1:0] sym);
    match_t m;
    logic [CNT_W:0] sum;
    m.status = dsc_pkg::ST_OK;
    case (op)
      dsc_pkg::OP_CLEAR: begin
        pat_len = 0;
        restart_text();
      end
      dsc_pkg::OP_APPEND: begin
        if (pat_len < PAT_DEPTH) begin
          pat_mem[pat_len] = sym;
          pat_len++;
          restart_text();
        end else begin
          m.status = dsc_pkg::ST_FULL;
        end
      end
      dsc_pkg::OP_TEXT: begin
        text_on = 1'b1;
        // Top down, so each entry adds the previous symbol's value of the one below.
        for (int j = pat_len; j >= 1; j--) begin
          if (pat_mem[j-1] == sym) begin
            sum = {1'b0, row[j]} + {1'b0, row[j-1]};
            if (sum[CNT_W]) begin
              row[j] = '1;
              sat_on = 1'b1;
            end else begin
              row[j] = sum[CNT_W-1:0];
            end
          end
        end
        if (sat_on) m.status = dsc_pkg::ST_SAT;
      end
      default: begin
        if (sat_on) m.status = dsc_pkg::ST_SAT;
      end
    endcase
    m.count = (pat_len == 0 || !text_on) ? '0 : row[pat_len];
    match_q.push_back(m);
  endfunction

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h", n_results, what, got, want);
    n_errors++;
  endtask

  // Driver: predicts on every accepted request and then offers the next one.
  always @(posedge clk) begin
    req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      gap_left = 0;
      pat_len = 0;
      for (int j = 0; j < PAT_DEPTH; j++) pat_mem[j] = '0;
      restart_text();
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        step_counter(in_tuser, in_tdata);
        n_accepted++;
        gap_left = (n_accepted % 160 < 40) ? 0 : pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (req_q.size() == 0 || (req_q[0].wait_idle && match_q.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        r = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= r.symbol;
        in_tuser <= r.opcode;
      end
    end
  end

  // Long receiver hold-offs, counted here so the block fills and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_no <= 0;
      long_hold <= 0;
    end else begin
      cycle_no <= cycle_no + 1;
      if (cycle_no == 2500 || cycle_no == 9000) long_hold <= 300;
      else if (long_hold > 0) long_hold <= long_hold - 1;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    match_t m;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rstall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (match_q.size() == 0) begin
          report_mismatch("unexpected result, count", out_tdata, '0);
        end else begin
          m = match_q.pop_front();
          if (out_tdata !== m.count) report_mismatch("match_count", out_tdata, m.count);
          if (out_tuser !== m.status) begin
            report_mismatch("status", 32'(out_tuser), 32'(m.status));
          end
        end
        n_results++;
      end
      if (rstall > 0) rstall--;
      else if (cycle_no % 1024 >= 256 && $urandom_range(0, 99) < 30) rstall = pick_gap();
      out_tready <= (rstall == 0) && (long_hold == 0);
    end
  end

  task automatic add_req(logic [dsc_pkg::OP_W-1:0] op, logic [dsc_pkg::SYM_W-1:0] sym,
                         bit hold = 1'b0);
    req_t r;
    r.opcode = op;
    r.symbol = sym;
    r.wait_idle = hold;
    req_q.push_back(r);
  endtask

  function automatic logic [dsc_pkg::SYM_W-1:0] pick_sym();
    if ($urandom_range(0, 9) == 0) return dsc_pkg::SYM_W'($urandom_range(0, 255));
    return alph[$urandom_range(0, alph_n - 1)];
  endfunction

  task automatic new_alphabet();
    alph_n = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) alph[i] = dsc_pkg::SYM_W'($urandom_range(0, 255));
  endtask

  initial begin
    int n_rand;
    int kind;
    int plen;
    int tlen;
    int episode;
    logic [dsc_pkg::SYM_W-1:0] s;

    // Directed part: empty pattern, extreme symbols, every opcode, restarts.
    add_req(dsc_pkg::OP_TEXT, 8'h41);
    add_req(OP_UNUSED, 8'h00);
    add_req(dsc_pkg::OP_APPEND, 8'h00);
    add_req(dsc_pkg::OP_APPEND, 8'hFF);
    add_req(dsc_pkg::OP_TEXT, 8'h00);
    add_req(dsc_pkg::OP_TEXT, 8'hFF);
    add_req(dsc_pkg::OP_TEXT, 8'h00);
    add_req(dsc_pkg::OP_TEXT, 8'hFF);
    add_req(dsc_pkg::OP_TEXT, 8'h5A);
    add_req(OP_UNUSED, 8'hFF);
    add_req(dsc_pkg::OP_CLEAR, 8'hFF);
    add_req(dsc_pkg::OP_TEXT, 8'hFF);
    add_req(dsc_pkg::OP_APPEND, 8'hAA);
    add_req(dsc_pkg::OP_TEXT, 8'hAA);
    add_req(dsc_pkg::OP_TEXT, 8'hAA);
    add_req(dsc_pkg::OP_TEXT, 8'hAA);
    add_req(dsc_pkg::OP_APPEND, 8'hAA);
    add_req(dsc_pkg::OP_TEXT, 8'hAA);
    add_req(dsc_pkg::OP_TEXT, 8'hAA);
    add_req(dsc_pkg::OP_TEXT, 8'h55);
    // The sender waits here until every earlier result has come back.
    add_req(dsc_pkg::OP_CLEAR, 8'h00, 1'b1);

    // Random part: mostly whole episodes of pattern load then text.
    n_rand = 0;
    episode = 0;
    while (n_rand < RANDOM_ITEMS) begin
      kind = (episode == 0) ? 75 : $urandom_range(0, 99);
      new_alphabet();
      if (kind < 62) begin
        if ($urandom_range(0, 3) != 0) begin
          add_req(dsc_pkg::OP_CLEAR, dsc_pkg::SYM_W'($urandom_range(0, 255)),
                  episode % 20 == 5);
          n_rand++;
        end
        plen = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        for (int i = 0; i < plen; i++) begin
          add_req(dsc_pkg::OP_APPEND, pick_sym());
          n_rand++;
        end
        tlen = $urandom_range(1, 30);
        for (int i = 0; i < tlen; i++) begin
          if ($urandom_range(0, 24) == 0) add_req(OP_UNUSED, pick_sym());
          else add_req(dsc_pkg::OP_TEXT, pick_sym());
          n_rand++;
        end
      end else if (kind < 72) begin
        // Full pattern, then appends that must be dropped.
        add_req(dsc_pkg::OP_CLEAR, dsc_pkg::SYM_W'($urandom_range(0, 255)));
        for (int i = 0; i < PAT_DEPTH + $urandom_range(1, 3); i++) begin
          add_req(dsc_pkg::OP_APPEND, pick_sym());
        end
        tlen = $urandom_range(2, 12);
        for (int i = 0; i < tlen; i++) add_req(dsc_pkg::OP_TEXT, pick_sym());
        add_req(dsc_pkg::OP_APPEND, pick_sym());
        n_rand += PAT_DEPTH + tlen + 5;
      end else if (kind < 80) begin
        // One repeated symbol grows counts binomially until they saturate.
        s = alph[0];
        plen = $urandom_range(14, 32);
        tlen = $urandom_range(45, 60);
        add_req(dsc_pkg::OP_CLEAR, s);
        for (int i = 0; i < plen; i++) add_req(dsc_pkg::OP_APPEND, s);
        for (int i = 0; i < tlen; i++) add_req(dsc_pkg::OP_TEXT, s);
        add_req(OP_UNUSED, s);
        add_req(dsc_pkg::OP_TEXT, ~s);
        add_req(dsc_pkg::OP_APPEND, s);
        add_req(dsc_pkg::OP_TEXT, s);
        n_rand += plen + tlen + 5;
      end else begin
        tlen = $urandom_range(5, 15);
        for (int i = 0; i < tlen; i++) begin
          add_req(dsc_pkg::OP_W'($urandom_range(0, 3)),
                  dsc_pkg::SYM_W'($urandom_range(0, 255)));
          n_rand++;
        end
      end
      episode++;
    end

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (req_q.size() != 0 || in_tvalid) @(posedge clk);
    while (match_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== distinct_subsequence_counter.f =====
rtl/core/dsc_pkg.sv
rtl/core/distinct_subsequence_counter.sv
bench/tb_top.sv
